>>> src/lds_pkg.sv
// Shared types and constants for the LED driver frame serializer.
// Holds the zone color layout, command codes and the frame slot map.
// No dependencies.
package lds_pkg;

  localparam int ZONE_COUNT     = 10;
  localparam int VALUE_BITS     = 12;
  localparam int FRAME_WORDS    = 32;
  localparam int ZONE_W         = 4;
  localparam int WORD_W         = $clog2(FRAME_WORDS);
  localparam int BITPOS_W       = $clog2(VALUE_BITS);
  localparam int FUNC_W         = 2;
  localparam int TICK_W         = 8;
  localparam int CFG_IDX_W      = 8;
  localparam int ZONES_PER_HALF = 5;

  // command codes
  localparam logic [FUNC_W-1:0] FUNC_WRITE_ZONE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE_ALL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START      = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_TICK       = 2'd3;

  // channel codes within one zone
  localparam logic [1:0] CHAN_BLUE  = 2'd0;
  localparam logic [1:0] CHAN_GREEN = 2'd1;
  localparam logic [1:0] CHAN_RED   = 2'd2;

  typedef logic [VALUE_BITS-1:0] level_t;

  typedef struct packed {
    level_t blue;
    level_t green;
    level_t red;
  } color_t;

  typedef struct packed {
    logic              wr_one;
    logic              wr_all;
    logic [ZONE_W-1:0] zone;
    color_t            color;
  } zone_wr_t;

  typedef struct packed {
    logic              pad;
    logic [ZONE_W-1:0] zone;
    logic [1:0]        chan;
  } slot_t;

  // Map a frame word to its zone and channel. The first half carries a pad
  // and zones 5..9, the second half a pad and zones 0..4.
  function automatic slot_t frame_slot(input logic [WORD_W-1:0] word);
    slot_t       s;
    logic [3:0]  rel_m1;
    logic [3:0]  off;
    logic [3:0]  rem;
    rel_m1 = word[WORD_W-2:0] - 4'd1;
    case (rel_m1) inside
      [4'd0:4'd2]:   off = 4'd0;
      [4'd3:4'd5]:   off = 4'd1;
      [4'd6:4'd8]:   off = 4'd2;
      [4'd9:4'd11]:  off = 4'd3;
      [4'd12:4'd14]: off = 4'd4;
      default:       off = 4'd0;
    endcase
    rem    = rel_m1 - ((off << 1) + off);
    s.pad  = (word[WORD_W-2:0] == '0);
    s.zone = (word[WORD_W-1] ? 4'd0 : 4'(ZONES_PER_HALF)) + off;
    s.chan = rem[1:0];
    return s;
  endfunction

endpackage

>>> src/lds_if.sv
// Handshake channel interfaces for the LED driver frame serializer.
// Depends on lds_pkg for field widths.
interface lds_in_if;
  import lds_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [ZONE_W-1:0] zone_index;
  level_t            red_level;
  level_t            green_level;
  level_t            blue_level;
  modport source (output valid, func, zone_index, red_level, green_level, blue_level,
                  input ready);
  modport sink (input valid, func, zone_index, red_level, green_level, blue_level,
                output ready);
endinterface

interface lds_out_if;
  logic valid;
  logic ready;
  logic serial_clock;
  logic serial_data;
  logic latch_line;
  logic busy_res;
  logic accepted;
  modport source (output valid, serial_clock, serial_data, latch_line, busy_res, accepted,
                  input ready);
  modport sink (input valid, serial_clock, serial_data, latch_line, busy_res, accepted,
                output ready);
endinterface

interface lds_cfg_if;
  import lds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TICK_W-1:0]    data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/lds_zone_store.sv
// Zone color registers and frame bit readout.
// Depends on lds_pkg (color layout, frame slot map).
module lds_zone_store (
  input  logic                     clk,
  input  logic                     rst_n,
  input  lds_pkg::zone_wr_t        wr,
  input  logic [lds_pkg::WORD_W-1:0]   rd_word,
  input  logic [lds_pkg::BITPOS_W-1:0] rd_bit,
  output logic                     bit_o
);
  import lds_pkg::*;

  color_t colors_r [ZONE_COUNT];
  slot_t  slot;
  color_t sel_color;
  level_t sel_level;
  logic [BITPOS_W-1:0] shift_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        colors_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < ZONE_COUNT; i++) begin
        if (wr.wr_all || (wr.wr_one && wr.zone == ZONE_W'(i))) begin
          colors_r[i] <= wr.color;
        end
      end
    end
  end

  always_comb begin
    slot      = frame_slot(rd_word);
    sel_color = '0;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      if (slot.zone == ZONE_W'(i)) begin
        sel_color = colors_r[i];
      end
    end
    case (slot.chan)
      CHAN_BLUE:  sel_level = sel_color.blue;
      CHAN_GREEN: sel_level = sel_color.green;
      CHAN_RED:   sel_level = sel_color.red;
      default:    sel_level = '0;
    endcase
    if (slot.pad) begin
      sel_level = '0;
    end
    // MSB first
    shift_idx = BITPOS_W'(VALUE_BITS - 1) - rd_bit;
    bit_o     = sel_level[shift_idx];
  end

endmodule

>>> src/led_driver_frame_serializer.sv
// Top level of the LED driver frame serializer: command decode, pin sequencer,
// configuration registers and the result skid buffer.
// Depends on lds_pkg, lds_if (channels) and lds_zone_store.
//
//   channel   dir  payload                                        transfer when
//   in_chan   in   func, zone_index, red/green/blue_level          valid && ready
//   out_chan  out  serial_clock, serial_data, latch_line,
//                  busy_res, accepted                              valid && ready
//   cfg_chan  in   index, data (4 tick registers)                  valid && ready
//
// Each item's state update and result are computed in the cycle of the
// transfer, and the result is registered before it appears on out_chan.
// One item per cycle is sustained; a stalled output holds one result in the
// output register and one in a skid register, and in_chan.ready drops only
// when both are full. Synchronous reset clears all zone colors and the
// sequencer at once. cfg_chan is always ready.
module led_driver_frame_serializer (
  input  logic      clk,
  input  logic      rst_n,
  lds_in_if.sink    in_chan,
  lds_out_if.source out_chan,
  lds_cfg_if.sink   cfg_chan
);
  import lds_pkg::*;

  // sequencer phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_SETUP = 3'd1;
  localparam logic [2:0] PH_HIGH  = 3'd2;
  localparam logic [2:0] PH_GAP   = 3'd3;
  localparam logic [2:0] PH_LATCH = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETUP      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_HIGH = 8'd3;

  typedef struct packed {
    logic serial_clock;
    logic serial_data;
    logic latch_line;
    logic busy_res;
    logic accepted;
  } res_t;

  logic [TICK_W-1:0] setup_ticks_r, clock_high_ticks_r, latch_gap_ticks_r, latch_high_ticks_r;

  logic [2:0]          phase_r, phase_nxt;
  logic [TICK_W-1:0]   ticks_r, ticks_nxt;
  logic [WORD_W-1:0]   word_r, word_nxt;
  logic [BITPOS_W-1:0] bit_r, bit_nxt;

  logic out_valid_r, skid_valid_r;
  res_t out_data_r, skid_data_r;

  logic              fire;
  logic              busy;
  logic [TICK_W-1:0] ticks_inc;
  zone_wr_t          zone_wr;
  logic              frame_bit;
  res_t              res;
  logic              pop;

  // ---------------------------------------------------------------------------
  // Configuration registers; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_ticks_r      <= 8'd1;
      clock_high_ticks_r <= 8'd1;
      latch_gap_ticks_r  <= 8'd1;
      latch_high_ticks_r <= 8'd2;
    end else if (cfg_chan.valid) begin
      case (cfg_chan.index)
        REG_SETUP:      setup_ticks_r      <= cfg_chan.data;
        REG_CLOCK_HIGH: clock_high_ticks_r <= cfg_chan.data;
        REG_LATCH_GAP:  latch_gap_ticks_r  <= cfg_chan.data;
        REG_LATCH_HIGH: latch_high_ticks_r <= cfg_chan.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Command decode and pin sequencer.
  // ---------------------------------------------------------------------------
  assign in_chan.ready = !skid_valid_r;
  assign fire          = in_chan.valid && in_chan.ready;
  assign busy          = (phase_r != PH_IDLE);
  assign ticks_inc     = ticks_r + 8'd1;

  always_comb begin
    phase_nxt = phase_r;
    ticks_nxt = ticks_r;
    word_nxt  = word_r;
    bit_nxt   = bit_r;
    if (fire && in_chan.func == FUNC_TICK && busy) begin
      // count the tick first, then compare against the phase length;
      // a length of zero therefore behaves as one tick
      ticks_nxt = ticks_inc;
      case (phase_r)
        PH_SETUP: begin
          if (ticks_inc >= setup_ticks_r) begin
            phase_nxt = PH_HIGH;
            ticks_nxt = '0;
          end
        end
        PH_HIGH: begin
          if (ticks_inc >= clock_high_ticks_r) begin
            ticks_nxt = '0;
            if (word_r == WORD_W'(FRAME_WORDS - 1) && bit_r == BITPOS_W'(VALUE_BITS - 1)) begin
              phase_nxt = PH_GAP;
            end else begin
              phase_nxt = PH_SETUP;
              if (bit_r == BITPOS_W'(VALUE_BITS - 1)) begin
                bit_nxt  = '0;
                word_nxt = word_r + 1'b1;
              end else begin
                bit_nxt = bit_r + 1'b1;
              end
            end
          end
        end
        PH_GAP: begin
          if (ticks_inc >= latch_gap_ticks_r) begin
            phase_nxt = PH_LATCH;
            ticks_nxt = '0;
          end
        end
        PH_LATCH: begin
          if (ticks_inc >= latch_high_ticks_r) begin
            phase_nxt = PH_IDLE;
            ticks_nxt = '0;
            word_nxt  = '0;
            bit_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          ticks_nxt = '0;
          word_nxt  = '0;
          bit_nxt   = '0;
        end
      endcase
    end else if (fire && in_chan.func == FUNC_START && !busy) begin
      phase_nxt = PH_SETUP;
      ticks_nxt = '0;
      word_nxt  = '0;
      bit_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      ticks_r <= '0;
      word_r  <= '0;
      bit_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      ticks_r <= ticks_nxt;
      word_r  <= word_nxt;
      bit_r   <= bit_nxt;
    end
  end

  // Zone writes are taken only while idle; an index past the last zone
  // matches no register and so changes nothing.
  always_comb begin
    zone_wr.wr_one      = fire && !busy && in_chan.func == FUNC_WRITE_ZONE;
    zone_wr.wr_all      = fire && !busy && in_chan.func == FUNC_WRITE_ALL;
    zone_wr.zone        = in_chan.zone_index;
    zone_wr.color.blue  = in_chan.blue_level;
    zone_wr.color.green = in_chan.green_level;
    zone_wr.color.red   = in_chan.red_level;
  end

  // Colors cannot change during a frame, so the bit for the next position
  // is read from the current registers.
  lds_zone_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (zone_wr),
    .rd_word (word_nxt),
    .rd_bit  (bit_nxt),
    .bit_o   (frame_bit)
  );

  // Pin levels after the item.
  always_comb begin
    res.serial_clock = (phase_nxt == PH_HIGH);
    res.serial_data  = (phase_nxt == PH_SETUP || phase_nxt == PH_HIGH) && frame_bit;
    res.latch_line   = (phase_nxt == PH_LATCH);
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.accepted     = !(busy && in_chan.func != FUNC_TICK);
  end

  // ---------------------------------------------------------------------------
  // Output register with skid stage.
  // ---------------------------------------------------------------------------
  assign pop = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop) begin
      if (skid_valid_r) begin
        // drain the skid entry; input is held off while it is full
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= fire;
      end
    end else if (fire) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (skid_valid_r) begin
        out_data_r <= skid_data_r;
      end else if (fire) begin
        out_data_r <= res;
      end
    end else if (fire) begin
      skid_data_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.serial_clock = out_data_r.serial_clock;
  assign out_chan.serial_data  = out_data_r.serial_data;
  assign out_chan.latch_line   = out_data_r.latch_line;
  assign out_chan.busy_res     = out_data_r.busy_res;
  assign out_chan.accepted     = out_data_r.accepted;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_idle_position: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> (word_r == '0 && bit_r == '0 && ticks_r == '0))
    else $error("idle with a nonzero frame position");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && busy && in_chan.func != FUNC_TICK) |=>
      (phase_r == $past(phase_r) && ticks_r == $past(ticks_r)))
    else $error("refused command changed the sequencer");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_chan.ready && skid_valid_r) |=> skid_valid_r)
    else $error("skid entry lost while output stalled");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for led_driver_frame_serializer: random and directed
// commands and ticks, scored against an in-bench model of the pin sequencer.
// Depends on lds_pkg, lds_if and the block's top level.
module tb_top;
  import lds_pkg::*;

  localparam int FRAME_BITS = FRAME_WORDS * VALUE_BITS;
  localparam int HALF_WORDS = FRAME_WORDS / 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_TICKS      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_HIGH_TICKS = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_GAP_TICKS  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LATCH_HIGH_TICKS = 8'd3;

  // pin sequencer phases
  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_SETUP, SEQ_HIGH, SEQ_GAP, SEQ_LATCH
  } seq_phase_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ZONE_W-1:0] zone;
    color_t            color;
  } command_t;

  typedef struct packed {
    logic sclk;
    logic sdata;
    logic latch;
    logic busy;
    logic accepted;
  } pins_t;

  logic clk;
  logic rst_n;

  lds_in_if  in_chan ();
  lds_out_if out_chan ();
  lds_cfg_if cfg_chan ();

  led_driver_frame_serializer i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  // Commands waiting to be driven, and pin levels waiting to be seen.
  command_t pending_cmds [$];
  pins_t    expected_pins [$];

  // Shadow of the block: zone colors, sequencer and timing registers.
  color_t           zone_mem [ZONE_COUNT];
  logic [8:0]       bit_idx;
  seq_phase_e       seq;
  logic [TICK_W-1:0] seq_ticks;
  logic [TICK_W-1:0] dur_setup;
  logic [TICK_W-1:0] dur_high;
  logic [TICK_W-1:0] dur_gap;
  logic [TICK_W-1:0] dur_latch;

  bit in_fire;
  int send_idle_pct;
  int recv_stall_pct;
  int fail_count;
  int cmds_sent;
  int refused_count;
  int frames_started;
  int results_checked;

  // Return the frame bit at position pos, MSB of each 12-bit word first.
  // Word 0 and word 16 are zero pads; the first half carries zones 5..9,
  // the second half zones 0..4, each as blue, green, red.
  function automatic logic frame_bit_of(input logic [8:0] pos);
    int     word;
    int     rel;
    int     zone;
    int     shift;
    level_t lvl;
    word  = int'(pos) / VALUE_BITS;
    shift = VALUE_BITS - 1 - int'(pos) % VALUE_BITS;
    rel   = word % HALF_WORDS;
    if (rel == 0) return 1'b0;
    zone = ((word < HALF_WORDS) ? ZONES_PER_HALF : 0) + (rel - 1) / 3;
    case ((rel - 1) % 3)
      CHAN_BLUE:  lvl = zone_mem[zone].blue;
      CHAN_GREEN: lvl = zone_mem[zone].green;
      default:    lvl = zone_mem[zone].red;
    endcase
    return lvl[shift];
  endfunction

  // Advance the sequencer by one tick. A zero duration expires after one tick.
  function automatic void seq_advance();
    seq_ticks = seq_ticks + 1'b1;
    case (seq)
      SEQ_SETUP: begin
        if (seq_ticks >= dur_setup) begin
          seq       = SEQ_HIGH;
          seq_ticks = '0;
        end
      end
      SEQ_HIGH: begin
        if (seq_ticks >= dur_high) begin
          seq_ticks = '0;
          if (int'(bit_idx) + 1 >= FRAME_BITS) begin
            seq = SEQ_GAP;
          end else begin
            bit_idx = bit_idx + 1'b1;
            seq     = SEQ_SETUP;
          end
        end
      end
      SEQ_GAP: begin
        if (seq_ticks >= dur_gap) begin
          seq       = SEQ_LATCH;
          seq_ticks = '0;
        end
      end
      SEQ_LATCH: begin
        if (seq_ticks >= dur_latch) begin
          seq       = SEQ_IDLE;
          seq_ticks = '0;
          bit_idx   = '0;
        end
      end
      default: begin
        seq       = SEQ_IDLE;
        seq_ticks = '0;
        bit_idx   = '0;
      end
    endcase
  endfunction

  // Apply one command to the shadow and return the pin levels that follow it.
  function automatic pins_t next_pin_levels(input command_t c);
    pins_t p;
    logic  busy;
    int    zi;
    busy       = (seq != SEQ_IDLE);
    p.accepted = 1'b1;
    if (c.func == FUNC_TICK) begin
      if (busy) seq_advance();
    end else if (busy) begin
      p.accepted    = 1'b0;
      refused_count = refused_count + 1;
    end else begin
      case (c.func)
        FUNC_WRITE_ZONE: begin
          if (c.zone < ZONE_COUNT) zone_mem[c.zone] = c.color;
        end
        FUNC_WRITE_ALL: begin
          for (zi = 0; zi < ZONE_COUNT; zi++) zone_mem[zi] = c.color;
        end
        default: begin
          seq            = SEQ_SETUP;
          seq_ticks      = '0;
          bit_idx        = '0;
          frames_started = frames_started + 1;
        end
      endcase
    end
    p.sclk  = (seq == SEQ_HIGH);
    p.sdata = (seq == SEQ_SETUP || seq == SEQ_HIGH) ? frame_bit_of(bit_idx) : 1'b0;
    p.latch = (seq == SEQ_LATCH);
    p.busy  = (seq != SEQ_IDLE);
    return p;
  endfunction

  task automatic check_pin(input string pin, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %b actual %b", $time, pin, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, reset and the limit on run time
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender: present the next pending command at the falling edge once the
  // current one has been transferred, idling at random.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : drive_cmds
    command_t cmd;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_fire) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        cmd                 = pending_cmds.pop_front();
        in_chan.func        <= cmd.func;
        in_chan.zone_index  <= cmd.zone;
        in_chan.red_level   <= cmd.color.red;
        in_chan.green_level <= cmd.color.green;
        in_chan.blue_level  <= cmd.color.blue;
        in_chan.valid       <= 1'b1;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // Receiver: stall the result channel at random.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: at each rising edge score the result transfer against the oldest
  // expectation, then predict the command transfer and track register writes.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_pins
    pins_t    got;
    pins_t    want;
    command_t cmd;
    if (!rst_n) begin
      in_fire = 1'b0;
    end else begin
      in_fire = in_chan.valid && in_chan.ready;
      if (out_chan.valid && out_chan.ready) begin
        got = '{sclk: out_chan.serial_clock, sdata: out_chan.serial_data,
                latch: out_chan.latch_line, busy: out_chan.busy_res,
                accepted: out_chan.accepted};
        if (expected_pins.size() == 0) begin
          $display("%0t: result with nothing expected, expected none actual %b",
                   $time, got);
          fail_count++;
        end else begin
          want = expected_pins.pop_front();
          check_pin("serial_clock", want.sclk, got.sclk);
          check_pin("serial_data", want.sdata, got.sdata);
          check_pin("latch_line", want.latch, got.latch);
          check_pin("busy_res", want.busy, got.busy);
          check_pin("accepted", want.accepted, got.accepted);
          results_checked++;
        end
      end
      if (in_fire) begin
        cmd.func        = in_chan.func;
        cmd.zone        = in_chan.zone_index;
        cmd.color.blue  = in_chan.blue_level;
        cmd.color.green = in_chan.green_level;
        cmd.color.red   = in_chan.red_level;
        expected_pins.push_back(next_pin_levels(cmd));
        cmds_sent++;
      end
      if (cfg_chan.valid && cfg_chan.ready) begin
        case (cfg_chan.index)
          REG_SETUP_TICKS:      dur_setup = cfg_chan.data;
          REG_CLOCK_HIGH_TICKS: dur_high  = cfg_chan.data;
          REG_LATCH_GAP_TICKS:  dur_gap   = cfg_chan.data;
          REG_LATCH_HIGH_TICKS: dur_latch = cfg_chan.data;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Bias levels toward the all-zero and all-one extremes.
  function automatic level_t any_level();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return level_t'($urandom);
    endcase
  endfunction

  function automatic color_t any_color();
    color_t c;
    c.blue  = any_level();
    c.green = any_level();
    c.red   = any_level();
    return c;
  endfunction

  task automatic push_cmd(input logic [FUNC_W-1:0] f, input logic [ZONE_W-1:0] z,
                          input color_t c);
    command_t cmd;
    cmd.func  = f;
    cmd.zone  = z;
    cmd.color = c;
    pending_cmds.push_back(cmd);
  endtask

  // Ticks from a start command until the block is idle again.
  function automatic int frame_tick_count(input int s, input int c, input int g,
                                          input int l);
    return FRAME_BITS * ((s == 0 ? 1 : s) + (c == 0 ? 1 : c))
           + (g == 0 ? 1 : g) + (l == 0 ? 1 : l);
  endfunction

  // Idle-time traffic: zone writes (in and out of range), write-all and ticks
  // that find nothing to do. Never a start.
  task automatic push_idle_writes(input int n);
    int k;
    int sel;
    for (k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 15) begin
        push_cmd(FUNC_TICK, ZONE_W'($urandom), any_color());
      end else if (sel < 25) begin
        push_cmd(FUNC_WRITE_ALL, ZONE_W'($urandom), any_color());
      end else if (sel < 40) begin
        push_cmd(FUNC_WRITE_ZONE, ZONE_W'($urandom_range(ZONE_COUNT, 15)), any_color());
      end else begin
        push_cmd(FUNC_WRITE_ZONE, ZONE_W'($urandom_range(0, ZONE_COUNT - 1)),
                 any_color());
      end
    end
  endtask

  // Start a frame, try every command while it runs, then tick it along.
  // Stray commands land only where the frame is surely still running.
  task automatic push_frame(input int ticks);
    int k;
    push_cmd(FUNC_START, ZONE_W'($urandom), any_color());
    push_cmd(FUNC_WRITE_ZONE, ZONE_W'($urandom_range(0, ZONE_COUNT - 1)), any_color());
    push_cmd(FUNC_WRITE_ALL, ZONE_W'($urandom), any_color());
    push_cmd(FUNC_START, ZONE_W'($urandom), any_color());
    for (k = 0; k < ticks; k++) begin
      if (k > 0 && k < ticks - 1 && $urandom_range(0, 99) < 5) begin
        push_cmd(FUNC_W'($urandom_range(0, 2)), ZONE_W'($urandom), any_color());
      end
      push_cmd(FUNC_TICK, ZONE_W'($urandom), any_color());
    end
  endtask

  // Hold until every command is transferred and every result has come back.
  task automatic wait_drained();
    @(posedge clk);
    while (pending_cmds.size() != 0 || in_chan.valid || expected_pins.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Write all four timing registers, one transfer each; call at a falling edge.
  task automatic load_timing(input logic [TICK_W-1:0] setup_t,
                             input logic [TICK_W-1:0] high_t,
                             input logic [TICK_W-1:0] gap_t,
                             input logic [TICK_W-1:0] latch_t);
    logic [TICK_W-1:0]    vals [4];
    logic [CFG_IDX_W-1:0] regs [4];
    int                   k;
    vals = '{setup_t, high_t, gap_t, latch_t};
    regs = '{REG_SETUP_TICKS, REG_CLOCK_HIGH_TICKS, REG_LATCH_GAP_TICKS,
             REG_LATCH_HIGH_TICKS};
    for (k = 0; k < 4; k++) begin
      cfg_chan.valid <= 1'b1;
      cfg_chan.index <= regs[k];
      cfg_chan.data  <= vals[k];
      @(posedge clk);
      while (!cfg_chan.ready) @(posedge clk);
      @(negedge clk);
    end
    cfg_chan.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int zi;
    // drive every input to a known value and load the reset state
    rst_n               = 1'b0;
    in_chan.valid       = 1'b0;
    in_chan.func        = FUNC_TICK;
    in_chan.zone_index  = '0;
    in_chan.red_level   = '0;
    in_chan.green_level = '0;
    in_chan.blue_level  = '0;
    out_chan.ready      = 1'b0;
    cfg_chan.valid      = 1'b0;
    cfg_chan.index      = REG_SETUP_TICKS;
    cfg_chan.data       = '0;
    in_fire             = 1'b0;
    fail_count          = 0;
    cmds_sent           = 0;
    refused_count       = 0;
    frames_started      = 0;
    results_checked     = 0;
    for (zi = 0; zi < ZONE_COUNT; zi++) zone_mem[zi] = '0;
    bit_idx   = '0;
    seq       = SEQ_IDLE;
    seq_ticks = '0;
    dur_setup = 8'd1;
    dur_high  = 8'd1;
    dur_gap   = 8'd1;
    dur_latch = 8'd2;
    send_idle_pct  = 35;
    recv_stall_pct = 66;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset timing: idle tick, write-all, zone extremes,
    // out-of-range zones, then a full frame with refused commands inside it.
    push_cmd(FUNC_TICK, '0, '0);
    push_cmd(FUNC_WRITE_ALL, 4'd3, '{blue: '1, green: '1, red: '1});
    push_cmd(FUNC_WRITE_ZONE, 4'd0, '{blue: '0, green: '0, red: '0});
    push_cmd(FUNC_WRITE_ZONE, 4'd9, '{blue: '1, green: '0, red: '1});
    push_cmd(FUNC_WRITE_ZONE, 4'd5, '{blue: 12'h800, green: 12'h001, red: '0});
    push_cmd(FUNC_WRITE_ZONE, 4'd10, '{blue: '0, green: '0, red: '0});
    push_cmd(FUNC_WRITE_ZONE, 4'd15, '{blue: '0, green: '1, red: '0});
    push_cmd(FUNC_WRITE_ZONE, 4'd4, any_color());
    push_cmd(FUNC_TICK, 4'd15, '{blue: '1, green: '1, red: '1});
    push_frame(frame_tick_count(1, 1, 1, 2));
    push_idle_writes(12);

    // Longest bit halves; run the first bits of a frame and leave it running.
    // Swap which side idles.
    wait_drained();
    send_idle_pct  = 66;
    recv_stall_pct = 35;
    @(negedge clk);
    load_timing(8'd255, 8'd255, 8'd7, 8'd3);
    @(posedge clk);
    push_idle_writes(10);
    push_frame(520);

    // Full rate: zero setup (acts as one tick) with the longest gap and latch
    // loaded while the frame runs; the new start is refused and ticks carry on.
    wait_drained();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    @(negedge clk);
    load_timing(8'd0, 8'd1, 8'd255, 8'd255);
    @(posedge clk);
    push_frame(60);

    // let trailing results arrive and catch any extra ones
    wait_drained();
    repeat (10) @(posedge clk);

    $display("%0d commands, %0d results checked, %0d refused while busy, %0d frames started",
             cmds_sent, results_checked, refused_count, frames_started);
    $display("timing: reset values over a full frame, 255-tick bits, zero setup mid-frame");
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
src/lds_pkg.sv
src/lds_if.sv
src/lds_zone_store.sv
src/led_driver_frame_serializer.sv
verif/tb_top.sv
